[rtl/zbpg_pkg.sv]
package zbpg_pkg;

    localparam int MAX_LINE_DEF = 4096;
    localparam int SIZE_W       = 13;
    localparam int WIDE_W       = SIZE_W + 1;
    localparam int ZONE_MAX     = 4096;
    localparam int ZCNT_W       = 12;
    localparam int ZIDX_W       = 2;
    localparam int LEVEL_W      = 8;
    localparam int PIXEL_W      = 32;
    localparam int LEVELS_W     = 64;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [ZIDX_W-1:0]   ZONE_LAST = 2'd3;

    localparam logic [SIZE_W-1:0]   LINE_WIDTH_RST  = 13'd1920;
    localparam logic [SIZE_W-1:0]   ZONE_WIDTH_RST  = 13'd480;
    localparam logic [SIZE_W-1:0]   ZONE_HEIGHT_RST = 13'd270;
    localparam logic [LEVEL_W-1:0]  WHITE_LEVEL_RST = 8'd220;
    localparam logic [LEVEL_W-1:0]  ALPHA_OPAQUE    = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LINE_WIDTH  = 3'd0,
        REG_ZONE_WIDTH  = 3'd1,
        REG_ZONE_HEIGHT = 3'd2,
        REG_GRAY_LOW    = 3'd3,
        REG_GRAY_HIGH   = 3'd4,
        REG_WHITE_LEVEL = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [ZIDX_W-1:0] row;
        logic [ZIDX_W-1:0] col;
    } t_zone;

endpackage

[rtl/zbpg_position.sv]
module zbpg_position #(
    parameter int MAX_LINE = zbpg_pkg::MAX_LINE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_frame_start,
    input  logic [zbpg_pkg::SIZE_W-1:0] i_line_width,
    input  logic [zbpg_pkg::SIZE_W-1:0] i_zone_width,
    input  logic [zbpg_pkg::SIZE_W-1:0] i_zone_height,
    output zbpg_pkg::t_zone             o_zone
);
    import zbpg_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE + 1);
    localparam int COL_W = $clog2(MAX_LINE);

    logic [COL_W-1:0]  r_col,  n_col;
    logic [ZCNT_W-1:0] r_ciz,  n_ciz;
    logic [ZCNT_W-1:0] r_riz,  n_riz;
    t_zone             r_zone, n_zone;

    logic [COL_W-1:0]  cur_col;
    logic [ZCNT_W-1:0] cur_ciz;
    logic [ZCNT_W-1:0] cur_riz;
    t_zone             cur_zone;

    logic [WIDE_W-1:0] lw_wide;
    logic [CNT_W-1:0]  lw;
    logic [SIZE_W-1:0] zw;
    logic [SIZE_W-1:0] zh;
    logic [CNT_W-1:0]  col_inc;
    logic [SIZE_W-1:0] ciz_inc;
    logic [SIZE_W-1:0] riz_inc;

    always_comb begin
        if (i_line_width == '0) begin
            lw_wide = WIDE_W'(1);
        end else if ({1'b0, i_line_width} > WIDE_W'(MAX_LINE)) begin
            lw_wide = WIDE_W'(MAX_LINE);
        end else begin
            lw_wide = {1'b0, i_line_width};
        end
        lw = lw_wide[CNT_W-1:0];

        if (i_zone_width == '0) begin
            zw = SIZE_W'(1);
        end else if (i_zone_width > SIZE_W'(ZONE_MAX)) begin
            zw = SIZE_W'(ZONE_MAX);
        end else begin
            zw = i_zone_width;
        end

        if (i_zone_height == '0) begin
            zh = SIZE_W'(1);
        end else if (i_zone_height > SIZE_W'(ZONE_MAX)) begin
            zh = SIZE_W'(ZONE_MAX);
        end else begin
            zh = i_zone_height;
        end
    end

    always_comb begin
        if (i_frame_start) begin
            cur_col  = '0;
            cur_ciz  = '0;
            cur_riz  = '0;
            cur_zone = '0;
        end else begin
            cur_col  = r_col;
            cur_ciz  = r_ciz;
            cur_riz  = r_riz;
            cur_zone = r_zone;
        end

        col_inc = CNT_W'(cur_col) + CNT_W'(1);
        ciz_inc = {1'b0, cur_ciz} + SIZE_W'(1);
        riz_inc = {1'b0, cur_riz} + SIZE_W'(1);

        n_col  = cur_col;
        n_ciz  = cur_ciz;
        n_riz  = cur_riz;
        n_zone = cur_zone;

        if (col_inc >= lw) begin
            n_col      = '0;
            n_ciz      = '0;
            n_zone.col = '0;
            if (riz_inc >= zh) begin
                n_riz = '0;
                if (cur_zone.row < ZONE_LAST) begin
                    n_zone.row = cur_zone.row + ZIDX_W'(1);
                end
            end else begin
                n_riz = riz_inc[ZCNT_W-1:0];
            end
        end else begin
            n_col = col_inc[COL_W-1:0];
            if (ciz_inc >= zw) begin
                n_ciz = '0;
                if (cur_zone.col < ZONE_LAST) begin
                    n_zone.col = cur_zone.col + ZIDX_W'(1);
                end
            end else begin
                n_ciz = ciz_inc[ZCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_ciz  <= '0;
            r_riz  <= '0;
            r_zone <= '0;
        end else if (i_advance) begin
            r_col  <= n_col;
            r_ciz  <= n_ciz;
            r_riz  <= n_riz;
            r_zone <= n_zone;
        end
    end

    assign o_zone = cur_zone;

endmodule

[rtl/zoned_bright_pixel_gray_mask.sv]
// An accepted word is registered in stage 1, its result in the output register.
// Throughput: one word per cycle unless m_tready stalls the output; the position
// counters and the threshold compare each settle within a single stage.
// Reset (synchronous, active low): pipeline emptied, position counters cleared,
// registers back to 1920 x 480 x 270 sizes, zero gray levels, white level 220.
module zoned_bright_pixel_gray_mask #(
    parameter int MAX_LINE = zbpg_pkg::MAX_LINE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [zbpg_pkg::PIXEL_W-1:0]    s_tdata,   // [31:0] pixel_in
    input  logic                            s_tuser,   // [0] frame_start

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [zbpg_pkg::PIXEL_W-1:0]    m_tdata,   // [31:0] pixel_out
    output logic                            m_tuser,   // [0] replaced

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [zbpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [zbpg_pkg::LEVELS_W-1:0]   i_cfg_data
);
    import zbpg_pkg::*;

    logic [SIZE_W-1:0]   r_line_width;
    logic [SIZE_W-1:0]   r_zone_width;
    logic [SIZE_W-1:0]   r_zone_height;
    logic [LEVELS_W-1:0] r_gray_low;
    logic [LEVELS_W-1:0] r_gray_high;
    logic [LEVEL_W-1:0]  r_white_level;

    logic                r_s1_valid;
    logic [PIXEL_W-1:0]  r_s1_pixel;
    t_zone               r_s1_zone;

    logic                r_m_valid;
    logic [PIXEL_W-1:0]  r_m_pixel;
    logic                r_m_repl;

    logic                s_accept;
    logic                s2_load;
    t_zone               zone;
    logic [PIXEL_W-1:0]  threshold;
    logic [2*LEVELS_W-1:0] levels;
    logic [LEVEL_W-1:0]  gray;
    logic                bright;
    logic [PIXEL_W-1:0]  n_m_pixel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width  <= LINE_WIDTH_RST;
            r_zone_width  <= ZONE_WIDTH_RST;
            r_zone_height <= ZONE_HEIGHT_RST;
            r_gray_low    <= '0;
            r_gray_high   <= '0;
            r_white_level <= WHITE_LEVEL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_LINE_WIDTH:  r_line_width  <= i_cfg_data[SIZE_W-1:0];
                REG_ZONE_WIDTH:  r_zone_width  <= i_cfg_data[SIZE_W-1:0];
                REG_ZONE_HEIGHT: r_zone_height <= i_cfg_data[SIZE_W-1:0];
                REG_GRAY_LOW:    r_gray_low    <= i_cfg_data;
                REG_GRAY_HIGH:   r_gray_high   <= i_cfg_data;
                REG_WHITE_LEVEL: r_white_level <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s2_load  = !r_m_valid || m_tready;
    assign s_tready = !r_s1_valid || s2_load;
    assign s_accept = s_tvalid && s_tready;

    zbpg_position #(
        .MAX_LINE(MAX_LINE)
    ) u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (s_accept),
        .i_frame_start (s_tuser),
        .i_line_width  (r_line_width),
        .i_zone_width  (r_zone_width),
        .i_zone_height (r_zone_height),
        .o_zone        (zone)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_tready) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_pixel <= s_tdata;
            r_s1_zone  <= zone;
        end
    end

    always_comb begin
        threshold = {ALPHA_OPAQUE, r_white_level, r_white_level, r_white_level};
        levels    = {r_gray_high, r_gray_low};
        gray      = levels[{r_s1_zone.row, r_s1_zone.col, 3'b000} +: LEVEL_W];
        bright    = r_s1_pixel > threshold;
        n_m_pixel = bright ? {ALPHA_OPAQUE, gray, gray, gray} : r_s1_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s2_load) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_s1_valid) begin
            r_m_pixel <= n_m_pixel;
            r_m_repl  <= bright;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_pixel;
    assign m_tuser  = r_m_repl;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import zbpg_pkg::*;

    localparam int LINE_CAP    = MAX_LINE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 160;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               replaced;
    } t_masked;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [PIXEL_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [LEVELS_W-1:0]   i_cfg_data  = '0;

    zoned_bright_pixel_gray_mask dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    logic [SIZE_W-1:0]   cfg_line_width  = LINE_WIDTH_RST;
    logic [SIZE_W-1:0]   cfg_zone_width  = ZONE_WIDTH_RST;
    logic [SIZE_W-1:0]   cfg_zone_height = ZONE_HEIGHT_RST;
    logic [LEVELS_W-1:0] cfg_gray_low    = '0;
    logic [LEVELS_W-1:0] cfg_gray_high   = '0;
    logic [LEVEL_W-1:0]  cfg_white       = WHITE_LEVEL_RST;

    int unsigned         col_count   = 0;
    int unsigned         col_in_zone = 0;
    int unsigned         row_in_zone = 0;
    logic [ZIDX_W-1:0]   zone_col    = '0;
    logic [ZIDX_W-1:0]   zone_row    = '0;

    t_masked masked_q[$];
    t_masked want;
    t_masked head;
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      tx_gap_pct  = 0;
    int      rx_stall_pct = 0;
    int      rx_hold     = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = $urandom_range(1, 11);
        end
        m_tready <= (rx_hold == 0);
    end

    function automatic int unsigned size_limit(logic [SIZE_W-1:0] v, int unsigned hi);
        if (v == '0)
            return 1;
        return (32'(v) > hi) ? hi : 32'(v);
    endfunction

    task mask_pixel(input logic [PIXEL_W-1:0] px, input logic fs, output t_masked res);
        int unsigned        lw;
        int unsigned        zw;
        int unsigned        zh;
        logic [PIXEL_W-1:0] thresh;
        logic [3:0]         zone;
        logic [LEVEL_W-1:0] g;
        lw = size_limit(cfg_line_width, LINE_CAP);
        zw = size_limit(cfg_zone_width, ZONE_MAX);
        zh = size_limit(cfg_zone_height, ZONE_MAX);
        thresh = {ALPHA_OPAQUE, cfg_white, cfg_white, cfg_white};
        if (fs) begin
            col_count   = 0;
            col_in_zone = 0;
            row_in_zone = 0;
            zone_col    = '0;
            zone_row    = '0;
        end
        if (px > thresh) begin
            zone = {zone_row, zone_col};
            g = zone[3] ? cfg_gray_high[zone[2:0]*8 +: 8] : cfg_gray_low[zone[2:0]*8 +: 8];
            res.pixel    = {ALPHA_OPAQUE, g, g, g};
            res.replaced = 1'b1;
        end else begin
            res.pixel    = px;
            res.replaced = 1'b0;
        end
        col_count++;
        if (col_count >= lw) begin
            col_count   = 0;
            col_in_zone = 0;
            zone_col    = '0;
            row_in_zone++;
            if (row_in_zone >= zh) begin
                row_in_zone = 0;
                if (zone_row != ZONE_LAST)
                    zone_row++;
            end
        end else begin
            col_in_zone++;
            if (col_in_zone >= zw) begin
                col_in_zone = 0;
                if (zone_col != ZONE_LAST)
                    zone_col++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_LINE_WIDTH:  cfg_line_width  = i_cfg_data[SIZE_W-1:0];
                    REG_ZONE_WIDTH:  cfg_zone_width  = i_cfg_data[SIZE_W-1:0];
                    REG_ZONE_HEIGHT: cfg_zone_height = i_cfg_data[SIZE_W-1:0];
                    REG_GRAY_LOW:    cfg_gray_low    = i_cfg_data;
                    REG_GRAY_HIGH:   cfg_gray_high   = i_cfg_data;
                    REG_WHITE_LEVEL: cfg_white       = i_cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                mask_pixel(s_tdata, s_tuser, want);
                masked_q.push_back(want);
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                if (masked_q.size() == 0) begin
                    $error("result word with no pixel pending: pixel_out %h", m_tdata);
                    fail_count++;
                end else begin
                    head = masked_q.pop_front();
                    if (m_tdata !== head.pixel) begin
                        $error("pixel_out expected %h actual %h", head.pixel, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== head.replaced) begin
                        $error("replaced expected %0b actual %0b", head.replaced, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic fs);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= fs;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (masked_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [LEVELS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bits beyond the register width get random fill half the time
    function automatic logic [LEVELS_W-1:0] with_fill(logic [LEVELS_W-1:0] v, int w);
        logic [LEVELS_W-1:0] fill;
        fill = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return v;
        return (fill << w) | v;
    endfunction

    task automatic load_config(input logic [SIZE_W-1:0] lw, input logic [SIZE_W-1:0] zw,
                               input logic [SIZE_W-1:0] zh, input logic [LEVELS_W-1:0] glo,
                               input logic [LEVELS_W-1:0] ghi, input logic [LEVEL_W-1:0] wl);
        write_reg(REG_LINE_WIDTH, with_fill(LEVELS_W'(lw), SIZE_W));
        write_reg(REG_ZONE_WIDTH, with_fill(LEVELS_W'(zw), SIZE_W));
        write_reg(REG_ZONE_HEIGHT, with_fill(LEVELS_W'(zh), SIZE_W));
        write_reg(REG_GRAY_LOW, glo);
        write_reg(REG_GRAY_HIGH, ghi);
        write_reg(REG_WHITE_LEVEL, with_fill(LEVELS_W'(wl), LEVEL_W));
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel(logic [LEVEL_W-1:0] wl);
        logic [PIXEL_W-1:0] px;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: px = {ALPHA_OPAQUE, 8'(wl + $urandom_range(0, 4) - 2),
                              8'(wl + $urandom_range(0, 4) - 2),
                              8'(wl + $urandom_range(0, 4) - 2)};
            4, 5, 6: px = $urandom;
            7: px = {ALPHA_OPAQUE, wl, wl, wl} + $urandom_range(0, 2) - 1;
            8: px = {8'($urandom_range(8'hFE, 8'hFF)), 24'($urandom)};
            default: px = ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
        return px;
    endfunction

    task automatic test_default_threshold();
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel({ALPHA_OPAQUE, WHITE_LEVEL_RST, WHITE_LEVEL_RST, WHITE_LEVEL_RST}, 1'b0);
        send_pixel({ALPHA_OPAQUE, WHITE_LEVEL_RST, WHITE_LEVEL_RST, WHITE_LEVEL_RST} + 1, 1'b0);
        send_pixel(32'hFEFF_FFFF, 1'b1);
        send_pixel(32'h00FF_FFFF, 1'b0);
        wait_idle();
    endtask

    // one-pixel zones on a 4-wide line visit all sixteen zones and fifteen levels (one pixel sits at the
    // threshold and is kept), then the rows run past the grid and stay on the bottom zone row
    task automatic test_zone_grid();
        logic [LEVELS_W-1:0] glo;
        logic [LEVELS_W-1:0] ghi;
        glo = {$urandom, $urandom};
        ghi = {$urandom, $urandom};
        load_config(13'd4, 13'd1, 13'd1, glo, ghi, 8'h80);
        for (int i = 0; i < 20; i++)
            send_pixel((i == 13) ? 32'hFF80_8080 : 32'hFFFF_FFFF, i == 0);
        wait_idle();
    endtask

    task automatic test_random_phase(input int idx);
        logic [SIZE_W-1:0]  lw;
        logic [SIZE_W-1:0]  zw;
        logic [SIZE_W-1:0]  zh;
        logic [LEVEL_W-1:0] wl;
        int unsigned        span;
        int                 frame_left;
        logic               fs;
        lw = SIZE_W'($urandom_range(1, 40));
        zw = SIZE_W'($urandom_range(1, 12));
        zh = SIZE_W'($urandom_range(1, 6));
        wl = LEVEL_W'($urandom);
        case (idx)
            0: begin lw = '0; zw = '0; zh = '0; end
            1: begin lw = 13'h1FFF; zw = 13'h1FFF; zh = 13'h1FFF; end
            2: begin lw = 13'd4096; zw = 13'd4096; zh = 13'd4096; wl = 8'h00; end
            3: begin lw = 13'd4097; zw = 13'd1; zh = 13'd1; wl = 8'hFF; end
            4: begin lw = 13'd5; zw = 13'd1; zh = 13'd1; end
            default: ;
        endcase
        tx_gap_pct   = (idx % 3 == 2 || idx == PHASES - 1) ? 0 : 20;
        rx_stall_pct = (idx % 3 == 2 || idx == PHASES - 1) ? 0 : 20;
        load_config(lw, zw, zh, {$urandom, $urandom}, {$urandom, $urandom}, wl);
        if (idx == 5)
            write_reg(REG_SPARE_A, {$urandom, $urandom});
        if (idx == 6)
            write_reg(REG_SPARE_B, {$urandom, $urandom});
        span = size_limit(lw, LINE_CAP) * size_limit(zh, ZONE_MAX) * 5;
        if (span > 400)
            span = 400;
        // half the phases carry on with the frame left from the last setting
        frame_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, span);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            fs = 1'b0;
            if (frame_left == 0) begin
                fs = 1'b1;
                frame_left = $urandom_range(1, span);
            end else if ($urandom_range(0, 199) == 0) begin
                fs = 1'b1;
            end
            frame_left--;
            send_pixel(random_pixel(wl), fs);
            if (idx == 1 && i == PHASE_ITEMS / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        test_default_threshold();
        test_zone_grid();
        for (int p = 0; p < PHASES; p++)
            test_random_phase(p);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && masked_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
